>>> rtl/differential_pulse_distance_framer_unit_macros.svh
// Assertion helpers for the pulse framer.
`ifndef DIFFERENTIAL_PULSE_DISTANCE_FRAMER_UNIT_MACROS_SVH
`define DIFFERENTIAL_PULSE_DISTANCE_FRAMER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define DPDF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed");
`define DPDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed");
`else
`define DPDF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define DPDF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/dpdf_pkg.sv
package dpdf_pkg;

   localparam int unsigned NUM_REGS    = 6;
   localparam int unsigned NUM_PERIODS = 5;
   localparam int unsigned MAX_PULSES  = 5;
   localparam int unsigned TIME_W      = 16;
   localparam int unsigned CODE_W      = 3;
   localparam int unsigned IDX_W       = 3;
   localparam int unsigned CSR_IDX_W   = 3;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam code_type CODE_ONE   = 3'd1;  // AGC, or a 0 bit after a 1 reference
   localparam code_type CODE_TWO   = 3'd2;
   localparam code_type CODE_THREE = 3'd3;
   localparam code_type CODE_STOP  = 3'd4;
   localparam code_type CODE_START = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD5 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STROBE  = 3'd5;

   typedef struct packed {
      code_type [MAX_PULSES-1:0] codes;
      idx_type                   count;
      logic                      prev_bit;
   } plan_type;

   function automatic code_type code_for(input logic prev, input logic bit_val);
      if (!prev) begin
         return bit_val ? CODE_THREE : CODE_TWO;
      end
      return bit_val ? CODE_TWO : CODE_ONE;
   endfunction

endpackage

>>> rtl/dpdf_if.sv
interface dpdf_req_if;
   logic valid;
   logic ready;
   logic data_bit;
   logic first_of_frame;
   logic last_of_frame;
   logic empty_frame;

   modport source (output valid, data_bit, first_of_frame, last_of_frame, empty_frame,
                   input ready);
   modport sink   (input valid, data_bit, first_of_frame, last_of_frame, empty_frame,
                   output ready);
endinterface

interface dpdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  pulse_code;
   logic [15:0] period_us;
   logic [15:0] low_us;
   logic [15:0] gap_us;
   logic        last_pulse;

   modport source (output valid, pulse_code, period_us, low_us, gap_us, last_pulse,
                   input ready);
   modport sink   (input valid, pulse_code, period_us, low_us, gap_us, last_pulse,
                   output ready);
endinterface

>>> rtl/differential_pulse_distance_framer_unit.sv
// Pulse framer: each accepted bit beat yields one to five pulse descriptors, one per
// cycle while the output register is free, in order AGC, AGC, START (when the bit
// opens a frame or the frame is empty), the data pulse (none for an empty frame), then
// STOP (when the bit closes a frame or the frame is empty). The sequencer holds an item
// until its final descriptor moves into the output register; the next bit is accepted
// in that same cycle. The user is to write the period registers and the strobe time
// through the csr port only while the block is idle; the block does not enforce this.
`include "differential_pulse_distance_framer_unit_macros.svh"

module differential_pulse_distance_framer_unit
   import dpdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dpdf_req_if.sink              req_ch,
   dpdf_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TIME_W-1:0]     csr_wdata
);

   time_type [NUM_PERIODS-1:0] period_ff;
   time_type                   strobe_ff;

   plan_type                   plan;
   code_type [MAX_PULSES-1:0]  seq_codes_ff;
   idx_type                    seq_count_ff;
   idx_type                    seq_idx_ff, seq_idx_in;
   logic                       busy_ff, busy_in;
   logic                       prev_bit_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   code_type                   rsp_code_ff;
   time_type                   rsp_period_ff;
   time_type                   rsp_low_ff;
   time_type                   rsp_gap_ff;
   logic                       rsp_last_ff;

   code_type                   cur_code;
   time_type                   cur_period;
   time_type                   cur_gap;
   logic                       out_free;
   logic                       advance;
   logic                       at_last;
   logic                       req_ready;
   logic                       accept;

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         strobe_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PERIOD1: period_ff[0] <= csr_wdata;
            REG_PERIOD2: period_ff[1] <= csr_wdata;
            REG_PERIOD3: period_ff[2] <= csr_wdata;
            REG_PERIOD4: period_ff[3] <= csr_wdata;
            REG_PERIOD5: period_ff[4] <= csr_wdata;
            REG_STROBE:  strobe_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   dpdf_plan u_plan (
      .data_bit       (req_ch.data_bit),
      .first_of_frame (req_ch.first_of_frame),
      .last_of_frame  (req_ch.last_of_frame),
      .empty_frame    (req_ch.empty_frame),
      .prev_bit       (prev_bit_ff),
      .plan           (plan)
   );

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign advance   = busy_ff && out_free;
   assign at_last   = (seq_idx_ff == idx_type'(seq_count_ff - IDX_W'(1)));
   assign req_ready = !busy_ff || (advance && at_last);
   assign accept    = req_ch.valid && req_ready;

   always_comb begin
      busy_in    = busy_ff;
      seq_idx_in = seq_idx_ff;
      if (accept) begin
         busy_in    = 1'b1;
         seq_idx_in = '0;
      end else if (advance) begin
         busy_in    = !at_last;
         seq_idx_in = idx_type'(seq_idx_ff + IDX_W'(1));
      end
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         seq_idx_ff   <= '0;
         prev_bit_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         seq_idx_ff   <= seq_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prev_bit_ff <= plan.prev_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seq_codes_ff <= plan.codes;
         seq_count_ff <= plan.count;
      end
   end

   assign cur_code = seq_codes_ff[seq_idx_ff];

   dpdf_pulse_fmt u_fmt (
      .code       (cur_code),
      .periods    (period_ff),
      .strobe_low (strobe_ff),
      .period_us  (cur_period),
      .gap_us     (cur_gap)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff   <= cur_code;
         rsp_period_ff <= cur_period;
         rsp_low_ff    <= strobe_ff;
         rsp_gap_ff    <= cur_gap;
         rsp_last_ff   <= at_last;
      end
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pulse_code = rsp_code_ff;
   assign rsp_ch.period_us  = rsp_period_ff;
   assign rsp_ch.low_us     = rsp_low_ff;
   assign rsp_ch.gap_us     = rsp_gap_ff;
   assign rsp_ch.last_pulse = rsp_last_ff;

   `DPDF_ASSERT_NEXT(a_accept_starts, clock, reset, accept, busy_ff && seq_idx_ff == '0)
   `DPDF_ASSERT_SAME(a_idx_in_range, clock, reset, busy_ff, seq_idx_ff < seq_count_ff)
   `DPDF_ASSERT_NEXT(a_last_marked, clock, reset, advance && at_last,
                     rsp_valid_ff && rsp_last_ff)
   `DPDF_ASSERT_SAME(a_code_legal, clock, reset, rsp_valid_ff,
                     rsp_code_ff >= CODE_ONE && rsp_code_ff <= CODE_START)

endmodule

>>> rtl/dpdf_plan.sv
module dpdf_plan
   import dpdf_pkg::*;
(
   input  logic     data_bit,
   input  logic     first_of_frame,
   input  logic     last_of_frame,
   input  logic     empty_frame,
   input  logic     prev_bit,
   output plan_type plan
);

   always_comb begin
      plan.codes    = {MAX_PULSES{CODE_ONE}};
      plan.count    = IDX_W'(1);
      plan.prev_bit = data_bit;
      if (empty_frame) begin
         plan.codes[0] = CODE_ONE;
         plan.codes[1] = CODE_ONE;
         plan.codes[2] = CODE_START;
         plan.codes[3] = CODE_STOP;
         plan.count    = IDX_W'(4);
         plan.prev_bit = 1'b1;
      end else if (first_of_frame) begin
         // preamble resets the reference to 1
         plan.codes[0] = CODE_ONE;
         plan.codes[1] = CODE_ONE;
         plan.codes[2] = CODE_START;
         plan.codes[3] = code_for(1'b1, data_bit);
         plan.codes[4] = CODE_STOP;
         plan.count    = last_of_frame ? IDX_W'(5) : IDX_W'(4);
      end else begin
         plan.codes[0] = code_for(prev_bit, data_bit);
         plan.codes[1] = CODE_STOP;
         plan.count    = last_of_frame ? IDX_W'(2) : IDX_W'(1);
      end
   end

endmodule

>>> rtl/dpdf_pulse_fmt.sv
module dpdf_pulse_fmt
   import dpdf_pkg::*;
(
   input  code_type                   code,
   input  time_type [NUM_PERIODS-1:0] periods,
   input  time_type                   strobe_low,
   output time_type                   period_us,
   output time_type                   gap_us
);

   always_comb begin
      case (code)
         CODE_ONE:   period_us = periods[0];
         CODE_TWO:   period_us = periods[1];
         CODE_THREE: period_us = periods[2];
         CODE_STOP:  period_us = periods[3];
         CODE_START: period_us = periods[4];
         default:    period_us = '0;
      endcase
      gap_us = (period_us > strobe_low) ? time_type'(period_us - strobe_low) : '0;
   end

endmodule

>>> tb/tb_differential_pulse_distance_framer_unit.sv
module tb_differential_pulse_distance_framer_unit;
   import dpdf_pkg::*;

   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned HOLD_AFTER  = 150;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_WAIT  = 12;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_B = 3'd7;

   typedef struct {
      logic data_bit;
      logic first_of_frame;
      logic last_of_frame;
      logic empty_frame;
   } frame_bit_type;

   typedef struct {
      code_type code;
      time_type period;
      time_type low;
      time_type gap;
      logic     last;
   } pulse_type;

   typedef enum {RX_OPEN, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0]    csr_wdata;

   dpdf_req_if req_ch();
   dpdf_rsp_if rsp_ch();

   differential_pulse_distance_framer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block: configuration and the reference bit
   time_type period_regs [0:NUM_PERIODS-1];
   time_type strobe_reg;
   logic     ref_bit;

   frame_bit_type bit_queue [$];
   pulse_type     pulse_queue [$];

   int unsigned queued_cnt;
   int unsigned accepted_cnt;
   int unsigned popped_cnt;
   int unsigned idle_cycles;
   int unsigned errors;

   // sender state
   logic offering;
   int   burst_left;
   int   gap_left;

   // receiver state
   rx_mode_type rx_mode;
   int unsigned rx_cycle;
   int unsigned hold_left;
   logic        held_off;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic void push_pulse(input code_type code, input logic fin);
      pulse_type p;
      p.code   = code;
      p.period = period_regs[int'(code) - 1];
      p.low    = strobe_reg;
      p.gap    = (p.period > strobe_reg) ? p.period - strobe_reg : '0;
      p.last   = fin;
      pulse_queue.push_back(p);
   endfunction

   function automatic void plan_pulses(input frame_bit_type fb);
      code_type data_code;
      if (fb.empty_frame || fb.first_of_frame) begin
         push_pulse(CODE_ONE, 1'b0);
         push_pulse(CODE_ONE, 1'b0);
         push_pulse(CODE_START, 1'b0);
         ref_bit = 1'b1;
      end
      if (fb.empty_frame) begin
         push_pulse(CODE_STOP, 1'b1);
      end else begin
         if (ref_bit)
            data_code = fb.data_bit ? CODE_TWO : CODE_ONE;
         else
            data_code = fb.data_bit ? CODE_THREE : CODE_TWO;
         push_pulse(data_code, !fb.last_of_frame);
         ref_bit = fb.data_bit;
         if (fb.last_of_frame)
            push_pulse(CODE_STOP, 1'b1);
      end
   endfunction

   task automatic check_pulse();
      pulse_type want;
      if (pulse_queue.size() == 0) begin
         report("unexpected descriptor, code", rsp_ch.pulse_code, 0);
         return;
      end
      want = pulse_queue.pop_front();
      if (rsp_ch.pulse_code !== want.code) report("pulse_code", rsp_ch.pulse_code, want.code);
      if (rsp_ch.period_us !== want.period) report("period_us", rsp_ch.period_us, want.period);
      if (rsp_ch.low_us !== want.low) report("low_us", rsp_ch.low_us, want.low);
      if (rsp_ch.gap_us !== want.gap) report("gap_us", rsp_ch.gap_us, want.gap);
      if (rsp_ch.last_pulse !== want.last) report("last_pulse", rsp_ch.last_pulse, want.last);
   endtask

   // monitor: prediction on input beats, checking on output beats, watchdog
   always @(posedge clock) begin
      logic got_beat;
      got_beat = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            plan_pulses('{req_ch.data_bit, req_ch.first_of_frame,
                          req_ch.last_of_frame, req_ch.empty_frame});
            accepted_cnt++;
            got_beat = 1'b1;
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            check_pulse();
            got_beat = 1'b1;
         end
         if (got_beat) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("[differential_pulse_distance_framer_unit] ERROR");
               $finish;
            end
         end
      end
   end

   // sender: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (popped_cnt != accepted_cnt) begin
            void'(bit_queue.pop_front());
            popped_cnt++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (bit_queue.size() > 0) begin
               offering = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 10);
                  gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_ch.valid <= offering;
         if (offering) begin
            req_ch.data_bit       <= bit_queue[0].data_bit;
            req_ch.first_of_frame <= bit_queue[0].first_of_frame;
            req_ch.last_of_frame  <= bit_queue[0].last_of_frame;
            req_ch.empty_frame    <= bit_queue[0].empty_frame;
         end
      end
   end

   // receiver: ready pattern drawn from random modes, plus one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (!held_off && accepted_cnt >= HOLD_AFTER) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         rx_cycle++;
         if (rx_cycle % 64 == 0)
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:    rsp_ch.ready <= 1'b1;
               RX_COIN:    rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               RX_CADENCE: rsp_ch.ready <= (rx_cycle % 5 != 0);
               default:    rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input time_type val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         REG_PERIOD1: period_regs[0] = val;
         REG_PERIOD2: period_regs[1] = val;
         REG_PERIOD3: period_regs[2] = val;
         REG_PERIOD4: period_regs[3] = val;
         REG_PERIOD5: period_regs[4] = val;
         REG_STROBE:  strobe_reg     = val;
         default: ;
      endcase
   endtask

   task automatic write_timing(input time_type p1, input time_type p2, input time_type p3,
                               input time_type p4, input time_type p5, input time_type strobe);
      write_reg(REG_PERIOD1, p1);
      write_reg(REG_PERIOD2, p2);
      write_reg(REG_PERIOD3, p3);
      write_reg(REG_PERIOD4, p4);
      write_reg(REG_PERIOD5, p5);
      write_reg(REG_STROBE, strobe);
   endtask

   task automatic queue_bit(input logic d, input logic f, input logic l, input logic e);
      bit_queue.push_back('{d, f, l, e});
      queued_cnt++;
   endtask

   // mostly well-formed frames, some noise beats
   task automatic queue_random_bits(input int unsigned count);
      int unsigned n;
      int unsigned len;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 99) < 15) begin
            queue_bit($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1));
            n++;
         end else begin
            len = $urandom_range(0, 10);
            if (len == 0) begin
               queue_bit($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                         1'b1);
               n++;
            end else begin
               for (int unsigned i = 0; i < len; i++) begin
                  queue_bit($urandom_range(0, 1), i == 0, i == len - 1, 1'b0);
                  n++;
               end
            end
         end
      end
   endtask

   task automatic drain();
      while (accepted_cnt != queued_cnt || pulse_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   initial begin
      time_type r;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.data_bit       = 1'b0;
      req_ch.first_of_frame = 1'b0;
      req_ch.last_of_frame  = 1'b0;
      req_ch.empty_frame    = 1'b0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < NUM_PERIODS; i++) period_regs[i] = '0;
      strobe_reg   = '0;
      ref_bit      = 1'b1;
      queued_cnt   = 0;
      accepted_cnt = 0;
      popped_cnt   = 0;
      errors       = 0;
      offering     = 1'b0;
      burst_left   = 4;
      gap_left     = 0;
      rx_mode      = RX_OPEN;
      rx_cycle     = 0;
      hold_left    = 0;
      held_off     = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // registers still at reset: everything zero
      queue_bit(1'b0, 1'b0, 1'b0, 1'b1);
      queue_bit(1'b1, 1'b1, 1'b1, 1'b0);
      queue_bit(1'b0, 1'b0, 1'b0, 1'b0);
      drain();

      write_timing(16'd100, 16'd200, 16'd300, 16'd400, 16'd500, 16'd250);
      write_reg(REG_UNUSED_A, 16'hffff);
      write_reg(REG_UNUSED_B, 16'h1234);
      queue_bit(1'b0, 1'b0, 1'b0, 1'b1);
      queue_bit(1'b1, 1'b1, 1'b1, 1'b1);   // empty frame ignores the other flags
      queue_bit(1'b0, 1'b1, 1'b1, 1'b0);
      queue_bit(1'b1, 1'b1, 1'b1, 1'b0);
      queue_bit(1'b1, 1'b1, 1'b0, 1'b0);
      queue_bit(1'b0, 1'b0, 1'b0, 1'b0);
      queue_bit(1'b0, 1'b0, 1'b0, 1'b0);
      queue_bit(1'b1, 1'b0, 1'b0, 1'b0);
      queue_bit(1'b1, 1'b0, 1'b0, 1'b0);
      queue_bit(1'b0, 1'b0, 1'b1, 1'b0);
      // after stop the last data bit is still the reference
      queue_bit(1'b0, 1'b0, 1'b0, 1'b0);
      queue_bit(1'b1, 1'b0, 1'b0, 1'b0);
      queue_bit(1'b1, 1'b0, 1'b1, 1'b0);
      queue_bit(1'b0, 1'b0, 1'b0, 1'b0);
      // preamble restores the 1 reference
      queue_bit(1'b0, 1'b1, 1'b0, 1'b0);
      queue_bit(1'b1, 1'b0, 1'b1, 1'b0);
      queue_bit(1'b0, 1'b0, 1'b0, 1'b0);
      queue_bit(1'b0, 1'b0, 1'b0, 1'b1);
      queue_bit(1'b1, 1'b0, 1'b0, 1'b0);
      drain();

      write_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
      queue_random_bits(100);
      drain();

      write_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
      queue_random_bits(100);
      drain();

      write_timing(16'hffff, 16'h0001, 16'hfffe, 16'h8000, 16'h7fff, 16'hffff);
      queue_random_bits(100);
      drain();

      for (int ph = 0; ph < 2; ph++) begin
         r = $urandom_range(0, 65535);
         write_timing($urandom_range(0, 65535), $urandom_range(0, 65535), r,
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      (ph == 0) ? r : time_type'($urandom_range(0, 65535)));
         queue_random_bits(100);
         drain();
      end

      if (errors == 0)
         $display("[differential_pulse_distance_framer_unit] OK");
      else
         $display("[differential_pulse_distance_framer_unit] ERROR");
      $finish;
   end

endmodule

>>> differential_pulse_distance_framer_unit.f
+incdir+rtl
rtl/dpdf_pkg.sv
rtl/dpdf_if.sv
rtl/dpdf_plan.sv
rtl/dpdf_pulse_fmt.sv
rtl/differential_pulse_distance_framer_unit.sv
tb/tb_differential_pulse_distance_framer_unit.sv
